// ----- rtl/tslc_pkg.sv -----
// Shared types and constants for the TCP source-address LRU counter.
// No dependencies; used by every other file of the block except tslc_ram.

package tslc_pkg;

	// Field widths fixed by the frame and result formats
	localparam int LEN_W   = 16;
	localparam int ETYPE_W = 16;
	localparam int PROTO_W = 8;
	localparam int KEY_W   = 32;
	localparam int SLOT_W  = 5;
	localparam int TOTAL_W = 64;

	// Frame qualification
	localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [PROTO_W-1:0] PROTO_TCP      = 8'd6;
	localparam logic [LEN_W-1:0]   MIN_IP_LEN     = 16'd34;
	localparam logic [LEN_W-1:0]   MIN_TCP_LEN    = 16'd54;

	// One table entry as stored in the entry memory
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [TOTAL_W-1:0] packets;
		logic [TOTAL_W-1:0] bytes;
	} entry_t;

	// Request from the front end to the table engine
	typedef struct packed {
		logic             start;
		logic             counted;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] length;
	} cmd_t;

	// Engine status toward the front end
	typedef struct packed {
		logic idle;
		logic done;
	} stat_t;

	// Result of one item
	typedef struct packed {
		logic               counted;
		logic               hit;
		logic               evicted;
		logic [SLOT_W-1:0]  slot;
		logic [TOTAL_W-1:0] packet_total;
		logic [TOTAL_W-1:0] byte_total;
	} res_t;

endpackage

// ----- rtl/tslc_if.sv -----
// Valid/ready channel interfaces for frame items and result items.
// Depends on tslc_pkg for field widths.

interface tslc_frame_if;
	logic                          valid;
	logic                          ready;
	logic [tslc_pkg::LEN_W-1:0]    frame_length;
	logic [tslc_pkg::ETYPE_W-1:0]  ether_type;
	logic [tslc_pkg::PROTO_W-1:0]  ip_protocol;
	logic [tslc_pkg::KEY_W-1:0]    source_ip;

	modport source (output valid, frame_length, ether_type, ip_protocol, source_ip,
		input ready);
	modport sink (input valid, frame_length, ether_type, ip_protocol, source_ip,
		output ready);
endinterface

interface tslc_result_if;
	logic                          valid;
	logic                          ready;
	logic                          counted;
	logic                          hit;
	logic                          evicted;
	logic [tslc_pkg::SLOT_W-1:0]   slot;
	logic [tslc_pkg::TOTAL_W-1:0]  packet_total;
	logic [tslc_pkg::TOTAL_W-1:0]  byte_total;

	modport source (output valid, counted, hit, evicted, slot, packet_total, byte_total,
		input ready);
	modport sink (input valid, counted, hit, evicted, slot, packet_total, byte_total,
		output ready);
endinterface

// ----- rtl/tcp_source_ip_lru_counter.sv -----
// Top level: frame qualification, table engine and output register.
// Depends on tslc_pkg, tslc_if and tslc_engine.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------
//  frame   | in  | valid / ready | frame_length, ether_type, ip_protocol,
//          |     |               | source_ip
//  result  | out | valid / ready | counted, hit, evicted, slot, packet_total,
//          |     |               | byte_total
//
// A counted frame goes through a key scan, an entry update and a rank rewrite
// before the next accept; the key scan and the rank rewrite each walk the
// filled entries one per cycle.
// A frame that fails qualification skips all three and goes straight to its
// result.
// Reset empties the table at once; ranks of unfilled entries are implied.
// A new frame is taken while the previous result waits in the output register;
// the engine then holds its finished result until that register frees up.

module tcp_source_ip_lru_counter #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	tslc_frame_if.sink    frame,
	tslc_result_if.source result
);

	tslc_pkg::cmd_t  cmd;
	tslc_pkg::stat_t stat;
	tslc_pkg::res_t  res;
	logic            take;
	logic            frame_ok;
	logic            out_valid_q;
	tslc_pkg::res_t  out_q;

	// qualification: IPv4, TCP, long enough for IP and TCP headers
	assign frame_ok = (frame.frame_length >= tslc_pkg::MIN_IP_LEN) &&
		(frame.ether_type == tslc_pkg::ETHERTYPE_IPV4) &&
		(frame.ip_protocol == tslc_pkg::PROTO_TCP) &&
		(frame.frame_length >= tslc_pkg::MIN_TCP_LEN);

	assign frame.ready  = stat.idle;
	assign cmd.start    = frame.valid && stat.idle;
	assign cmd.counted  = frame_ok;
	assign cmd.key      = frame.source_ip;
	assign cmd.length   = frame.frame_length;

	tslc_engine #(.N(TABLE_ENTRIES)) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.take   (take),
		.stat   (stat),
		.res    (res)
	);

	// output register
	assign take = stat.done && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.counted      = out_q.counted;
	assign result.hit          = out_q.hit;
	assign result.evicted      = out_q.evicted;
	assign result.slot         = out_q.slot;
	assign result.packet_total = out_q.packet_total;
	assign result.byte_total   = out_q.byte_total;

endmodule

// ----- rtl/tslc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.

module tslc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/tslc_engine.sv -----
// Table engine: key scan, entry update and recency-rank pass over two RAMs.
// Depends on tslc_pkg and tslc_ram.

module tslc_engine #(
	parameter int N = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tslc_pkg::cmd_t    cmd,
	input  logic              take,
	output tslc_pkg::stat_t   stat,
	output tslc_pkg::res_t    res
);

	localparam int IDX_W = $clog2(N);
	localparam int CNT_W = $clog2(N + 1);
	localparam int ENT_W = $bits(tslc_pkg::entry_t);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_RANK = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(N);
	localparam logic [IDX_W-1:0] LRU_RANK = IDX_W'(N - 1);

	// control state
	logic [2:0]       state_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] rd_q;
	logic             v_s1;
	logic             counted_q;
	logic             hit_q;
	logic             evict_q;

	// item and search payload
	logic [IDX_W-1:0]            a_s1;
	logic [tslc_pkg::KEY_W-1:0]  key_q;
	logic [tslc_pkg::LEN_W-1:0]  len_q;
	logic [IDX_W-1:0]            hit_idx_q;
	logic [IDX_W-1:0]            hit_rank_q;
	logic [tslc_pkg::TOTAL_W-1:0] hit_pk_q;
	logic [tslc_pkg::TOTAL_W-1:0] hit_by_q;
	logic [IDX_W-1:0]            lru_idx_q;
	logic [IDX_W-1:0]            idx_q;
	logic [IDX_W-1:0]            old_q;
	logic [tslc_pkg::TOTAL_W-1:0] pk_q;
	logic [tslc_pkg::TOTAL_W-1:0] by_q;

	// memory ports
	logic [ENT_W-1:0]  ent_rdata;
	logic [ENT_W-1:0]  ent_wdata;
	logic              ent_we;
	logic [IDX_W-1:0]  rank_rdata;
	logic [IDX_W-1:0]  rank_wdata;
	logic              rank_we;
	logic [IDX_W-1:0]  raddr;
	tslc_pkg::entry_t  ent_rd;

	// update decision
	logic                         full;
	logic [IDX_W-1:0]             upd_idx;
	logic [IDX_W-1:0]             upd_old;
	logic [tslc_pkg::TOTAL_W-1:0] upd_pk;
	logic [tslc_pkg::TOTAL_W-1:0] upd_by;

	logic scan_more;
	logic pass_end;
	logic in_pass;

	assign ent_rd    = tslc_pkg::entry_t'(ent_rdata);
	assign scan_more = (rd_q < fill_q);
	assign pass_end  = !scan_more && !v_s1;
	assign in_pass   = (state_q == ST_SCAN) || (state_q == ST_RANK);
	assign raddr     = rd_q[IDX_W-1:0];
	assign full      = (fill_q == FULL_CNT);

	// Valid entries always form the prefix below fill_q, and an invalid
	// entry's rank equals its index, so both passes cover only that prefix.
	tslc_ram #(.WIDTH(ENT_W), .DEPTH(N)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (upd_idx),
		.wdata (ent_wdata),
		.raddr (raddr),
		.rdata (ent_rdata)
	);

	tslc_ram #(.WIDTH(IDX_W), .DEPTH(N)) u_rank_ram (
		.clk   (clk),
		.we    (rank_we),
		.waddr (a_s1),
		.wdata (rank_wdata),
		.raddr (raddr),
		.rdata (rank_rdata)
	);

	// hit, free entry or LRU victim
	always_comb begin
		priority if (hit_q) begin
			upd_idx = hit_idx_q;
			upd_old = hit_rank_q;
			upd_pk  = hit_pk_q + tslc_pkg::TOTAL_W'(1);
			upd_by  = hit_by_q + tslc_pkg::TOTAL_W'(len_q);
		end else if (!full) begin
			upd_idx = fill_q[IDX_W-1:0];
			upd_old = fill_q[IDX_W-1:0];
			upd_pk  = tslc_pkg::TOTAL_W'(1);
			upd_by  = tslc_pkg::TOTAL_W'(len_q);
		end else begin
			upd_idx = lru_idx_q;
			upd_old = LRU_RANK;
			upd_pk  = tslc_pkg::TOTAL_W'(1);
			upd_by  = tslc_pkg::TOTAL_W'(len_q);
		end
	end

	assign ent_we    = (state_q == ST_UPD);
	assign ent_wdata = {key_q, upd_pk, upd_by};

	// rank rewrite: used entry to front, younger entries age by one
	assign rank_we    = (state_q == ST_RANK) && v_s1;
	assign rank_wdata = (a_s1 == idx_q) ? '0 :
		((rank_rdata < old_q) ? IDX_W'(rank_rdata + 1'b1) : rank_rdata);

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			rd_q      <= '0;
			v_s1      <= 1'b0;
			counted_q <= 1'b0;
			hit_q     <= 1'b0;
			evict_q   <= 1'b0;
		end else begin
			// read issue for both passes
			if (in_pass && scan_more) begin
				rd_q <= rd_q + 1'b1;
				v_s1 <= 1'b1;
			end else begin
				v_s1 <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						counted_q <= cmd.counted;
						hit_q     <= 1'b0;
						evict_q   <= 1'b0;
						rd_q      <= '0;
						state_q   <= cmd.counted ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (v_s1 && !hit_q && ent_rd.key == key_q) begin
						hit_q <= 1'b1;
					end
					if (pass_end) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (!hit_q && !full) begin
						fill_q <= fill_q + 1'b1;
					end
					evict_q <= !hit_q && full;
					rd_q    <= '0;
					state_q <= ST_RANK;
				end
				ST_RANK: begin
					if (pass_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and search payload
	always_ff @(posedge clk) begin
		a_s1 <= raddr;
		if (state_q == ST_IDLE && cmd.start) begin
			key_q <= cmd.key;
			len_q <= cmd.length;
		end
		if (state_q == ST_SCAN && v_s1) begin
			if (!hit_q && ent_rd.key == key_q) begin
				hit_idx_q  <= a_s1;
				hit_rank_q <= rank_rdata;
				hit_pk_q   <= ent_rd.packets;
				hit_by_q   <= ent_rd.bytes;
			end
			if (rank_rdata == LRU_RANK) begin
				lru_idx_q <= a_s1;
			end
		end
		if (state_q == ST_UPD) begin
			idx_q <= upd_idx;
			old_q <= upd_old;
			pk_q  <= upd_pk;
			by_q  <= upd_by;
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);

	// result, all zero for a frame that is not counted
	always_comb begin
		res = '0;
		if (counted_q) begin
			res.counted      = 1'b1;
			res.hit          = hit_q;
			res.evicted      = evict_q;
			res.slot         = tslc_pkg::SLOT_W'(idx_q);
			res.packet_total = pk_q;
			res.byte_total   = by_q;
		end
	end

endmodule

// ----- rtl/tslc_checker.sv -----
// Port-level checks for the TCP source-address LRU counter, bound to the top.
// Depends on tslc_pkg for field widths.

module tslc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          f_valid,
	input logic                          f_ready,
	input logic                          r_valid,
	input logic                          r_ready,
	input logic                          counted,
	input logic                          hit,
	input logic                          evicted,
	input logic [tslc_pkg::SLOT_W-1:0]   slot,
	input logic [tslc_pkg::TOTAL_W-1:0]  packet_total,
	input logic [tslc_pkg::TOTAL_W-1:0]  byte_total
);

	// one item in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && f_ready |=> !f_ready)
		else $error("frame taken while the engine was busy");

	// an uncounted frame reports all zero
	a_uncounted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !counted |-> !hit && !evicted && slot == '0 &&
			packet_total == '0 && byte_total == '0)
		else $error("uncounted item has nonzero fields");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |-> !(hit && evicted))
		else $error("hit and evicted both set");

	// a fresh entry starts at one packet
	a_miss_one_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && counted && !hit |-> packet_total == 64'd1)
		else $error("new entry packet count is not one");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid &&
			$stable({counted, hit, evicted, slot, packet_total, byte_total}))
		else $error("result changed while stalled");

endmodule

bind tcp_source_ip_lru_counter tslc_checker u_tslc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.f_valid      (frame.valid),
	.f_ready      (frame.ready),
	.r_valid      (result.valid),
	.r_ready      (result.ready),
	.counted      (result.counted),
	.hit          (result.hit),
	.evicted      (result.evicted),
	.slot         (result.slot),
	.packet_total (result.packet_total),
	.byte_total   (result.byte_total)
);

// ----- sim/tb_tcp_source_ip_lru_counter.sv -----
`timescale 1ns / 100ps
// Testbench for tcp_source_ip_lru_counter: drives parsed frames, predicts each result item
// with its own LRU table model, and checks every result field.
// Depends on tslc_pkg, tslc_if and the top level of the block.

module tb_tcp_source_ip_lru_counter;

	localparam int ENTRIES       = 32;
	localparam int STALL_LIMIT   = 1000;
	localparam int RANDOM_FRAMES = 1450;
	localparam int QUIET_FRAMES  = 200;
	localparam int POOL_SIZE     = 48;
	localparam int SEGMENT       = 200;
	localparam int MAX_REPORTS   = 10;

	// Per-address tally table with exact LRU replacement
	class flow_tally;
		bit                           filled[ENTRIES];
		logic [tslc_pkg::KEY_W-1:0]   keys[ENTRIES];
		logic [tslc_pkg::TOTAL_W-1:0] packets[ENTRIES];
		logic [tslc_pkg::TOTAL_W-1:0] bytes[ENTRIES];
		int unsigned                  rank[ENTRIES];
		tslc_pkg::res_t               pending[$];
		int                           errors;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				filled[i]  = 1'b0;
				keys[i]    = '0;
				packets[i] = '0;
				bytes[i]   = '0;
				rank[i]    = i;
			end
			errors = 0;
		endfunction

		// Predict the result of one accepted frame and queue it
		function void take_frame(logic [tslc_pkg::LEN_W-1:0] len,
				logic [tslc_pkg::ETYPE_W-1:0] etype,
				logic [tslc_pkg::PROTO_W-1:0] proto, logic [tslc_pkg::KEY_W-1:0] ip);
			tslc_pkg::res_t r;
			int             idx;
			bit             found;
			int unsigned    old_rank;
			int unsigned    top_rank;
			r = '0;
			if (len >= tslc_pkg::MIN_IP_LEN && etype == tslc_pkg::ETHERTYPE_IPV4 &&
					proto == tslc_pkg::PROTO_TCP && len >= tslc_pkg::MIN_TCP_LEN) begin
				idx = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (idx < 0 && filled[i] && keys[i] == ip)
						idx = i;
				found = (idx >= 0);
				if (found) begin
					packets[idx] = packets[idx] + 1;
					bytes[idx]   = bytes[idx] + tslc_pkg::TOTAL_W'(len);
				end else begin
					// lowest free entry first, else the least recently used one
					for (int i = 0; i < ENTRIES; i++)
						if (idx < 0 && !filled[i])
							idx = i;
					if (idx < 0) begin
						top_rank = 0;
						for (int i = 0; i < ENTRIES; i++)
							if (rank[i] >= top_rank) begin
								top_rank = rank[i];
								idx = i;
							end
						r.evicted = 1'b1;
					end
					filled[idx]  = 1'b1;
					keys[idx]    = ip;
					packets[idx] = 1;
					bytes[idx]   = tslc_pkg::TOTAL_W'(len);
				end
				// move the used entry to the front
				old_rank = rank[idx];
				for (int i = 0; i < ENTRIES; i++)
					if (rank[i] < old_rank)
						rank[i] = rank[i] + 1;
				rank[idx] = 0;
				r.counted      = 1'b1;
				r.hit          = found;
				r.slot         = idx[tslc_pkg::SLOT_W-1:0];
				r.packet_total = packets[idx];
				r.byte_total   = bytes[idx];
			end
			pending.push_back(r);
		endfunction

		// Compare one result item with the oldest prediction
		function void check_result(tslc_pkg::res_t got);
			tslc_pkg::res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result item with none pending: %p", $realtime, got);
				return;
			end
			want = pending.pop_front();
			if (got.counted !== want.counted || got.hit !== want.hit ||
					got.evicted !== want.evicted || got.slot !== want.slot ||
					got.packet_total !== want.packet_total ||
					got.byte_total !== want.byte_total) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: mismatch expected cnt=%b hit=%b ev=%b slot=%0d pk=%h by=%h",
						$realtime, want.counted, want.hit, want.evicted, want.slot,
						want.packet_total, want.byte_total);
					$display("%0t:          actual   cnt=%b hit=%b ev=%b slot=%0d pk=%h by=%h",
						$realtime, got.counted, got.hit, got.evicted, got.slot,
						got.packet_total, got.byte_total);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tslc_frame_if  frame_ch();
	tslc_result_if result_ch();

	tcp_source_ip_lru_counter #(
		.TABLE_ENTRIES(ENTRIES)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.frame (frame_ch),
		.result(result_ch)
	);

	flow_tally tally = new();

	int idle_pct;
	bit quiet;
	int quiet_cycles;
	logic [tslc_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one frame, wait for its handshake, then note it
	task send_frame(logic [tslc_pkg::LEN_W-1:0] len, logic [tslc_pkg::ETYPE_W-1:0] etype,
			logic [tslc_pkg::PROTO_W-1:0] proto, logic [tslc_pkg::KEY_W-1:0] ip);
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			frame_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		frame_ch.valid        <= 1'b1;
		frame_ch.frame_length <= len;
		frame_ch.ether_type   <= etype;
		frame_ch.ip_protocol  <= proto;
		frame_ch.source_ip    <= ip;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
		tally.take_frame(len, etype, proto, ip);
	endtask

	// Result side back-pressure in random bursts
	initial begin
		int hold;
		hold = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
				hold = $urandom_range(1, 6) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		tslc_pkg::res_t seen;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen.counted      = result_ch.counted;
			seen.hit          = result_ch.hit;
			seen.evicted      = result_ch.evicted;
			seen.slot         = result_ch.slot;
			seen.packet_total = result_ch.packet_total;
			seen.byte_total   = result_ch.byte_total;
			tally.check_result(seen);
		end
	end

	// Watchdog: no item moving on either channel for too long
	initial begin
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb_tcp_source_ip_lru_counter: done, errors");
		$finish;
	end

	// Stimulus
	initial begin
		int                           pool_span;
		int                           pick;
		logic [tslc_pkg::LEN_W-1:0]   len;
		logic [tslc_pkg::ETYPE_W-1:0] etype;
		logic [tslc_pkg::PROTO_W-1:0] proto;
		logic [tslc_pkg::KEY_W-1:0]   ip;

		arst_n                <= 1'b0;
		frame_ch.valid        <= 1'b0;
		frame_ch.frame_length <= '0;
		frame_ch.ether_type   <= '0;
		frame_ch.ip_protocol  <= '0;
		frame_ch.source_ip    <= '0;
		quiet     = 1'b0;
		idle_pct  = 20;
		pool_span = POOL_SIZE;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length limits around both thresholds
		send_frame(16'd0, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP, 32'h0A00_0001);
		send_frame(16'd33, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP, 32'h0A00_0001);
		send_frame(tslc_pkg::MIN_IP_LEN, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP,
			32'h0A00_0001);
		send_frame(16'd53, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP, 32'h0A00_0001);
		// first fills of free entries, extreme keys and lengths
		send_frame(tslc_pkg::MIN_TCP_LEN, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP,
			32'h0000_0000);
		send_frame(16'hFFFF, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP, 32'hFFFF_FFFF);
		send_frame(16'hFFFF, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP, 32'h0000_0000);
		// wrong ethertype
		send_frame(16'd60, 16'h0801, tslc_pkg::PROTO_TCP, 32'h0000_0000);
		send_frame(16'd60, 16'hFFFF, tslc_pkg::PROTO_TCP, 32'h0000_0000);
		send_frame(16'd60, 16'h0000, tslc_pkg::PROTO_TCP, 32'h0000_0000);
		send_frame(16'd60, 16'h86DD, tslc_pkg::PROTO_TCP, 32'h0000_0000);
		// wrong protocol
		send_frame(16'd60, tslc_pkg::ETHERTYPE_IPV4, 8'd0, 32'h0000_0000);
		send_frame(16'd60, tslc_pkg::ETHERTYPE_IPV4, 8'd7, 32'h0000_0000);
		send_frame(16'd60, tslc_pkg::ETHERTYPE_IPV4, 8'd17, 32'h0000_0000);
		send_frame(16'd60, tslc_pkg::ETHERTYPE_IPV4, 8'hFF, 32'h0000_0000);
		// hits and recency reordering
		send_frame(16'd100, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP, 32'hFFFF_FFFF);
		send_frame(16'd1500, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP, 32'hC0A8_0001);
		send_frame(16'd64, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP, 32'h0000_0000);
		send_frame(16'd64, tslc_pkg::ETHERTYPE_IPV4, tslc_pkg::PROTO_TCP, 32'hC0A8_0001);
		send_frame(16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);

		// random part: mostly TCP frames from a key pool, some noise
		for (int n = 0; n < RANDOM_FRAMES; n++) begin
			if (n % SEGMENT == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
				// spans above the table size force LRU replacement
				case ($urandom_range(0, 2))
					0: pool_span = 20;
					1: pool_span = 36;
					default: pool_span = POOL_SIZE;
				endcase
			end
			quiet = (n >= RANDOM_FRAMES - QUIET_FRAMES);

			etype = tslc_pkg::ETHERTYPE_IPV4;
			proto = tslc_pkg::PROTO_TCP;
			pick  = $urandom_range(0, 9);
			if (pick == 0)
				len = tslc_pkg::MIN_TCP_LEN;
			else if (pick == 1)
				len = 16'hFFFF;
			else
				len = tslc_pkg::LEN_W'($urandom_range(tslc_pkg::MIN_TCP_LEN, 16'hFFFF));
			if ($urandom_range(0, 9) == 0)
				ip = $urandom;
			else
				ip = key_pool[$urandom_range(0, pool_span - 1)];

			if ($urandom_range(0, 99) < 20) begin
				case ($urandom_range(0, 3))
					0: begin
						len   = tslc_pkg::LEN_W'($urandom);
						etype = tslc_pkg::ETYPE_W'($urandom);
						proto = tslc_pkg::PROTO_W'($urandom);
						ip    = $urandom;
					end
					1: len = tslc_pkg::LEN_W'($urandom_range(0, tslc_pkg::MIN_TCP_LEN - 1));
					2: begin
						etype = tslc_pkg::ETYPE_W'($urandom);
						if (etype == tslc_pkg::ETHERTYPE_IPV4)
							etype[0] = 1'b1;
					end
					default: begin
						proto = tslc_pkg::PROTO_W'($urandom);
						if (proto == tslc_pkg::PROTO_TCP)
							proto[0] = 1'b1;
					end
				endcase
			end
			send_frame(len, etype, proto, ip);
		end
		frame_ch.valid <= 1'b0;

		// drain, then a tail to catch stray result items
		while (tally.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (tally.errors == 0 && tally.pending.size() == 0)
			$display("tb_tcp_source_ip_lru_counter: done, clean");
		else
			$display("tb_tcp_source_ip_lru_counter: done, errors");
		$finish;
	end

endmodule
